// File: hw/rtl/lphm_pkg.sv
// Package with shared types and constants for the linear-probing hash map.
`timescale 1ns / 1ps
package lphm_pkg;
  localparam int DEFAULT_DEPTH = 32;
  localparam int KEY_W = 31;
  localparam int DATA_W = 32;
  localparam int TOTAL_W = 6;
  localparam int OPC_W = 2;

  localparam logic [OPC_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPC_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OPC_W-1:0] OP_FIND = 2'd2;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_LIVE = 2'd1,
    ST_TOMB = 2'd2
  } slot_st_t;

  typedef struct packed {
    logic [OPC_W-1:0] opcode;
    logic [KEY_W-1:0] key;
    logic [DATA_W-1:0] data_in;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic found;
    logic table_full;
    logic [TOTAL_W-1:0] entry_total;
    logic is_empty;
  } rsp_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_CHECK,
    BK_RESULT
  } bk_state_t;
endpackage

// File: hw/rtl/lphm_if.sv
// Valid/ready channel interface carrying one payload.
`timescale 1ns / 1ps
interface lphm_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/linear_probe_hash_map.sv
// Top level of the linear-probing hash map with tombstones.
//
//   Channel | Dir | Payload
//   in      | in  | opcode, key, data_in
//   out     | out | data_out, found, table_full, entry_total, is_empty
//
// A command enters a two-entry queue, then the back end probes the slots one at a
// time through the registered-read slot memories, alternating read and check
// states, up to TABLE_DEPTH probes at full load.
// Reset is synchronous and active low; it empties the table through per-slot
// valid bits, so no clearing pass is needed.
// Until both entries are full, the queue keeps accepting transfers while the
// back end works or a result waits for its transfer in the output register.
`timescale 1ns / 1ps
module linear_probe_hash_map #(
  parameter int TABLE_DEPTH = lphm_pkg::DEFAULT_DEPTH
) (
  input logic clk,
  input logic rst_n,
  lphm_if.sink in_ch,
  lphm_if.source out_ch
);
  import lphm_pkg::*;
  logic q_valid, q_pop;
  cmd_t q_cmd;

  // Front end takes transfers and decouples them from the probe engine.
  lphm_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_cmd(in_ch.payload),
    .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd));

  // Back end walks the probe sequence and registers the result.
  lphm_back #(.DEPTH(TABLE_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_rsp(out_ch.payload));
endmodule

// File: hw/rtl/lphm_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module lphm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end
endmodule

// File: hw/rtl/lphm_front.sv
// Front end: accepts commands and holds them in a two-entry queue.
`timescale 1ns / 1ps
module lphm_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  lphm_pkg::cmd_t in_cmd,
  output logic           q_valid,
  input  logic           q_pop,
  output lphm_pkg::cmd_t q_cmd
);
  import lphm_pkg::*;
  cmd_t ent_r [2];
  logic rd_r, wr_r;
  logic [1:0] cnt_r;
  logic push;

  assign in_ready = (cnt_r != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = ent_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= 1'b0;
      wr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (q_pop && q_valid) begin
        rd_r <= ~rd_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop && q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= in_cmd;
    end
  end
endmodule

// File: hw/rtl/lphm_back.sv
// Back end: probes the slot memories one slot per step and produces the result.
`timescale 1ns / 1ps
module lphm_back #(
  parameter int DEPTH = lphm_pkg::DEFAULT_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_pop,
  input  lphm_pkg::cmd_t q_cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output lphm_pkg::rsp_t out_rsp
);
  import lphm_pkg::*;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  bk_state_t state_r, state_nxt;
  cmd_t cmd_r;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] live_r, live_nxt;
  logic [DEPTH-1:0] vld_r;
  rsp_t rsp_r, rsp_nxt;
  logic ov_r, ov_nxt;

  logic st_we, kd_we;
  logic [1:0] st_wd, st_rd;
  logic [KEY_W-1:0] key_rd;
  logic [DATA_W-1:0] dat_rd;
  logic [AW-1:0] addr;
  logic [1:0] st_eff;
  logic live_hit;
  logic [AW-1:0] home;

  assign home = AW'(q_cmd.key % DEPTH);
  assign addr = (state_r == BK_IDLE) ? home : idx_r;

  lphm_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_st (
    .clk(clk), .we(st_we), .addr(addr), .wdata(st_wd), .rdata(st_rd));
  lphm_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_key (
    .clk(clk), .we(kd_we), .addr(addr), .wdata(cmd_r.key), .rdata(key_rd));
  lphm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_dat (
    .clk(clk), .we(kd_we), .addr(addr), .wdata(cmd_r.data_in), .rdata(dat_rd));

  assign st_eff = vld_r[idx_r] ? st_rd : ST_EMPTY;
  assign live_hit = (st_eff == ST_LIVE) && (key_rd == cmd_r.key);
  assign out_valid = ov_r;
  assign out_rsp = rsp_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    n_nxt = n_r;
    live_nxt = live_r;
    rsp_nxt = rsp_r;
    ov_nxt = ov_r;
    q_pop = 1'b0;
    st_we = 1'b0;
    kd_we = 1'b0;
    st_wd = ST_LIVE;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      BK_IDLE: begin
        // The result register is reused by the next command, so a new command
        // starts only once the previous result has left or is leaving now.
        if (q_valid && (!ov_r || out_ready)) begin
          q_pop = 1'b1;
          idx_nxt = home;
          n_nxt = '0;
          state_nxt = BK_CHECK;
        end
      end
      BK_READ: begin
        state_nxt = BK_CHECK;
      end
      BK_CHECK: begin
        rsp_nxt = '0;
        if (cmd_r.opcode == OP_INSERT) begin
          if (st_eff != ST_LIVE || key_rd == cmd_r.key) begin
            st_we = 1'b1;
            kd_we = 1'b1;
            if (st_eff != ST_LIVE) begin
              live_nxt = live_r + 1'b1;
            end
            state_nxt = BK_RESULT;
          end
        end else if (cmd_r.opcode == OP_DELETE || cmd_r.opcode == OP_FIND) begin
          if (st_eff == ST_EMPTY) begin
            state_nxt = BK_RESULT;
          end else if (live_hit) begin
            rsp_nxt.data_out = dat_rd;
            rsp_nxt.found = 1'b1;
            if (cmd_r.opcode == OP_DELETE) begin
              st_we = 1'b1;
              st_wd = ST_TOMB;
              if (live_r != '0) begin
                live_nxt = live_r - 1'b1;
              end
            end
            state_nxt = BK_RESULT;
          end
        end else begin
          state_nxt = BK_RESULT;
        end
        if (state_nxt == BK_CHECK) begin
          if (n_r == CW'(DEPTH - 1)) begin
            rsp_nxt.table_full = (cmd_r.opcode == OP_INSERT);
            state_nxt = BK_RESULT;
          end else begin
            n_nxt = n_r + 1'b1;
            idx_nxt = (idx_r == AW'(DEPTH - 1)) ? '0 : idx_r + 1'b1;
            state_nxt = BK_READ;
          end
        end
      end
      BK_RESULT: begin
        if (!ov_r || out_ready) begin
          rsp_nxt.entry_total = TOTAL_W'(live_r);
          rsp_nxt.is_empty = (live_r == '0);
          ov_nxt = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      ov_r <= 1'b0;
      live_r <= '0;
      vld_r <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
      live_r <= live_nxt;
      if (st_we) begin
        vld_r[idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_cmd;
    end
    idx_r <= idx_nxt;
    n_r <= n_nxt;
    rsp_r <= rsp_nxt;
  end
endmodule

// File: test/tb_top.sv
// Testbench for the linear-probing hash map: directed and random operations checked by a model.
`timescale 1ns / 1ps
module tb_top;
  import lphm_pkg::*;

  localparam int DEPTH = DEFAULT_DEPTH;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

  logic clk;
  logic rst_n;

  lphm_if #(.T(cmd_t)) cmd_ch (.clk(clk));
  lphm_if #(.T(rsp_t)) rsp_ch (.clk(clk));

  linear_probe_hash_map #(.TABLE_DEPTH(DEPTH)) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(cmd_ch.sink),
    .out_ch(rsp_ch.source)
  );

  // The testbench keeps its own image of the table and predicts every response
  // at the moment the command transfer happens.
  slot_st_t mirror_status [DEPTH];
  logic [KEY_W-1:0] mirror_key [DEPTH];
  logic [DATA_W-1:0] mirror_data [DEPTH];
  int unsigned mirror_count;
  rsp_t pending_rsp [$];

  int mismatches;
  int cycles;
  bit timed_out;
  // Idling percentages for each side; zero gives a stretch with no idling.
  int send_idle_pct;
  int recv_idle_pct;
  // While set, the receiver refuses every transfer.
  bit hold_off;
  // Keys of earlier inserts, up to 64, so that random operations can hit live entries.
  logic [KEY_W-1:0] key_pool [$];

  always #10 clk = ~clk;

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cmd_ch.valid = 1'b0;
    cmd_ch.payload = '0;
    rsp_ch.ready = 1'b0;
  end

  // Computes the response of one command and applies it to the table image.
  function automatic rsp_t predict_rsp(cmd_t c);
    rsp_t r;
    int idx;
    int hit;
    r = '0;
    idx = int'(c.key % DEPTH);
    hit = -1;
    if (c.opcode == OP_INSERT) begin
      r.table_full = 1'b1;
      for (int n = 0; n < DEPTH; n++) begin
        if (mirror_status[idx] != ST_LIVE || mirror_key[idx] == c.key) begin
          if (mirror_status[idx] != ST_LIVE) mirror_count++;
          mirror_status[idx] = ST_LIVE;
          mirror_key[idx] = c.key;
          mirror_data[idx] = c.data_in;
          r.table_full = 1'b0;
          break;
        end
        idx = (idx + 1) % DEPTH;
      end
    end else if (c.opcode == OP_DELETE || c.opcode == OP_FIND) begin
      // Lookups stop at an empty slot and skip tombstones.
      for (int n = 0; n < DEPTH; n++) begin
        if (mirror_status[idx] == ST_EMPTY) break;
        if (mirror_status[idx] == ST_LIVE && mirror_key[idx] == c.key) begin
          hit = idx;
          break;
        end
        idx = (idx + 1) % DEPTH;
      end
      if (hit >= 0) begin
        r.data_out = mirror_data[hit];
        r.found = 1'b1;
        if (c.opcode == OP_DELETE) begin
          mirror_status[hit] = ST_TOMB;
          if (mirror_count > 0) mirror_count--;
        end
      end
    end
    r.entry_total = mirror_count[TOTAL_W-1:0];
    r.is_empty = (mirror_count == 0);
    return r;
  endfunction

  // Offers one command and waits for its transfer; the prediction is made then.
  // Valid stays high after the transfer so that back-to-back commands need no
  // second assignment in the same time step; idling or drain_rsp drops it.
  task automatic send_cmd(logic [OPC_W-1:0] op, logic [KEY_W-1:0] k,
                          logic [DATA_W-1:0] d);
    cmd_t c;
    c.opcode = op;
    c.key = k;
    c.data_in = d;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.payload <= c;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    pending_rsp.push_back(predict_rsp(c));
    if (op == OP_INSERT && key_pool.size() < 64) key_pool.push_back(k);
  endtask

  // Stops offering commands and pauses the sender until every predicted
  // response has been checked.
  task automatic drain_rsp();
    cmd_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // Receiver: random ready, and every transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response %h at cycle %0d", rsp_ch.payload, cycles);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_ch.payload.data_out !== want.data_out ||
            rsp_ch.payload.found !== want.found ||
            rsp_ch.payload.table_full !== want.table_full ||
            rsp_ch.payload.entry_total !== want.entry_total ||
            rsp_ch.payload.is_empty !== want.is_empty) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at cycle %0d: expected %h, got %h",
                     cycles, want, rsp_ch.payload);
        end
      end
    end
    rsp_ch.ready <= rst_n && !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // Cycle counter that ends a run that has hung.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic logic [KEY_W-1:0] pick_key();
    if (key_pool.size() != 0 && $urandom_range(99) < 65)
      return key_pool[$urandom_range(key_pool.size() - 1)];
    // Small keys (0 to 95) share home slots; wide keys exercise every key bit.
    if ($urandom_range(1)) return KEY_W'($urandom_range(95));
    return KEY_W'($urandom);
  endfunction

  // Extremes of the fields, every opcode, collisions with wrap-around,
  // tombstone reuse, lookups past tombstones and a miss.
  task automatic test_directed();
    send_cmd(OP_FIND, '0, '0);
    send_cmd(OP_DELETE, '1, '1);
    send_cmd(OP_INSERT, '1, 32'h8000_0000);
    send_cmd(OP_INSERT, KEY_W'(DEPTH - 1 + 2 * DEPTH), 32'h7FFF_FFFF);
    send_cmd(OP_INSERT, KEY_W'(DEPTH - 1 + 4 * DEPTH), 32'hFFFF_FFFF);
    send_cmd(OP_FIND, KEY_W'(DEPTH - 1 + 4 * DEPTH), '0);
    send_cmd(OP_INSERT, '1, 32'h1234_5678);
    send_cmd(OP_DELETE, KEY_W'(DEPTH - 1 + 2 * DEPTH), '0);
    send_cmd(OP_FIND, KEY_W'(DEPTH - 1 + 4 * DEPTH), '1);
    send_cmd(OP_INSERT, KEY_W'(DEPTH - 1), 32'h0000_0001);
    send_cmd(OP_UNUSED, '1, '1);
    send_cmd(OP_FIND, KEY_W'(DEPTH - 1 + 8 * DEPTH), '0);
    send_cmd(OP_DELETE, '1, '0);
    send_cmd(OP_DELETE, '1, '0);
    send_cmd(OP_INSERT, '0, 32'h5555_AAAA);
    send_cmd(OP_FIND, '0, '0);
    send_cmd(OP_DELETE, KEY_W'(DEPTH - 1 + 4 * DEPTH), '0);
    send_cmd(OP_DELETE, KEY_W'(DEPTH - 1), '0);
    send_cmd(OP_DELETE, '0, '0);
    drain_rsp();
  endtask

  // Fills every slot, overflows the table, then looks up through a full table.
  task automatic test_full_table();
    for (int i = 0; i < DEPTH + 2; i++)
      send_cmd(OP_INSERT, KEY_W'(1000 + 7 * i), $urandom);
    send_cmd(OP_INSERT, KEY_W'(1000), 32'hCAFE_0000);
    send_cmd(OP_FIND, KEY_W'(5), '0);
    send_cmd(OP_FIND, KEY_W'(1000 + 7 * (DEPTH - 1)), '0);
    // Replace every entry with a tombstone, then probe across the tombstones.
    for (int i = 0; i < DEPTH; i++)
      send_cmd(OP_DELETE, KEY_W'(1000 + 7 * i), '0);
    send_cmd(OP_FIND, KEY_W'(3), '0);
    send_cmd(OP_INSERT, KEY_W'(3), $urandom);
    send_cmd(OP_DELETE, KEY_W'(3), '0);
    drain_rsp();
  endtask

  // The receiver holds off while commands keep coming, so the block stalls its input.
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (150) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < 20; i++)
          send_cmd(OP_INSERT, pick_key(), $urandom);
        drain_rsp();
      end
    join
  endtask

  task automatic test_random(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      // A quiet stretch with no idling on either side.
      if (i == count / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (i == count / 2) begin
        send_idle_pct = 21;
        recv_idle_pct = 21;
      end
      r = $urandom_range(99);
      if (r < 45) send_cmd(OP_INSERT, pick_key(), $urandom);
      else if (r < 70) send_cmd(OP_DELETE, pick_key(), $urandom);
      else if (r < 97) send_cmd(OP_FIND, pick_key(), $urandom);
      else send_cmd(OP_UNUSED, pick_key(), $urandom);
    end
    drain_rsp();
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      mirror_status[i] = ST_EMPTY;
      mirror_key[i] = '0;
      mirror_data[i] = '0;
    end
    mirror_count = 0;
    mismatches = 0;
    cycles = 0;
    hold_off = 1'b0;
    send_idle_pct = 21;
    recv_idle_pct = 21;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_full_table();
    test_backpressure();
    test_random(440);

    // Let any stray response show up before the verdict.
    repeat (2 * DEPTH + 20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule

// File: files.f
hw/rtl/lphm_pkg.sv
hw/rtl/lphm_if.sv
hw/rtl/lphm_ram.sv
hw/rtl/lphm_front.sv
hw/rtl/lphm_back.sv
hw/rtl/linear_probe_hash_map.sv
test/tb_top.sv
